// ----- sv/vrc_pkg.sv -----
// Package for the volume ray compositor: fixed widths, register indexes,
// control structs and the exp ROM tables. No dependencies.
package vrc_pkg;

    localparam int EXP_FRAC_BITS = 8;
    localparam int COLOR_BITS    = 16;
    localparam int X_W           = 8 + EXP_FRAC_BITS;
    localparam int EF_SIZE       = 1 << EXP_FRAC_BITS;
    localparam int ACC_SHR       = (COLOR_BITS >= 16) ? COLOR_BITS - 16 : 0;
    localparam int ACC_SHL       = (COLOR_BITS < 16) ? 16 - COLOR_BITS : 0;

    localparam logic [24:0] ONE_Q24 = 25'h1000000;

    localparam logic [1:0] REG_EXTINCTION = 2'd0;
    localparam logic [1:0] REG_DEEP_MODE  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    typedef logic [24:0] ei_rom_t [256];
    typedef logic [24:0] ef_rom_t [EF_SIZE];

    typedef struct packed {
        logic capture;
        logic calc_x;
        logic calc_att;
        logic calc_w;
        logic calc_acc;
        logic finish;
    } vrc_cmd_t;

    typedef struct packed {
        logic need_out;
        logic out_free;
    } vrc_status_t;

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] yq);
        longint      sum;
        logic [63:0] term;
        sum  = longint'(1) << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * yq) >> 30) / 64'(k);
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    function automatic ei_rom_t build_ei();
        ei_rom_t     t;
        logic [63:0] e1;
        logic [63:0] v;
        e1   = exp_neg_q30(64'd1 << 30);
        v    = 64'd1 << 30;
        t[0] = ONE_Q24;
        for (int i = 1; i < 256; i++) begin
            v    = (v * e1 + (64'd1 << 29)) >> 30;
            t[i] = 25'((v + 64'd32) >> 6);
        end
        return t;
    endfunction

    function automatic ef_rom_t build_ef();
        ef_rom_t t;
        for (int i = 0; i < EF_SIZE; i++) begin
            t[i] = 25'((exp_neg_q30(64'(i) << (30 - EXP_FRAC_BITS)) + 64'd32) >> 6);
        end
        return t;
    endfunction

    localparam ei_rom_t EI_ROM = build_ei();
    localparam ef_rom_t EF_ROM = build_ef();

    function automatic logic [15:0] alpha_of(input logic [24:0] t);
        logic [24:0] a;
        a = (t >= ONE_Q24) ? 25'd0 : ((ONE_Q24 - t) >> 8);
        return (a > 25'hFFFF) ? 16'hFFFF : a[15:0];
    endfunction

    function automatic logic [15:0] acc_to_q16(input logic [COLOR_BITS-1:0] acc);
        logic [47:0] r;
        r = 48'(acc);
        r = (r >> ACC_SHR) << ACC_SHL;
        return (r > 48'hFFFF) ? 16'hFFFF : r[15:0];
    endfunction

endpackage

// ----- sv/vrc_ctrl.sv -----
// Controller for the volume ray compositor: steps one sample through the
// datapath stages. Depends on vrc_pkg.
module vrc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  vrc_pkg::vrc_status_t status,
    output vrc_pkg::vrc_cmd_t    cmd
);
    import vrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_XMUL = 6'b000010,
        S_ATT  = 6'b000100,
        S_WMUL = 6'b001000,
        S_ACC  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_XMUL;
                end
            end
            S_XMUL: begin
                cmd.calc_x = 1'b1;
                state_next = S_ATT;
            end
            S_ATT: begin
                cmd.calc_att = 1'b1;
                state_next   = S_WMUL;
            end
            S_WMUL: begin
                cmd.calc_w = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.calc_acc = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (!status.need_out || status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/vrc_datapath.sv -----
// Datapath for the volume ray compositor: config registers, exp lookup,
// transmittance and color accumulation, result register. Depends on vrc_pkg.
module vrc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [23:0]          cfg_wdata,
    input  logic [87:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [87:0]          m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser,
    input  vrc_pkg::vrc_cmd_t    cmd,
    output vrc_pkg::vrc_status_t status
);
    import vrc_pkg::*;

    logic [15:0] ext_reg;
    logic        deep_reg;
    logic [23:0] thr_reg;

    logic [15:0] dens_reg;
    logic [15:0] col_reg [3];
    logic [23:0] dep_reg;
    logic        last_reg;

    logic [X_W-1:0]        x_reg;
    logic [24:0]           att_reg;
    logic [24:0]           w_reg;
    logic [24:0]           tnew_reg;
    logic [15:0]           dcol_reg [3];
    logic [24:0]           t_reg;
    logic [COLOR_BITS-1:0] acc_reg [3];
    logic                  stop_reg;

    logic        m_valid_reg;
    logic [87:0] m_data_reg;
    logic        m_last_reg;
    logic [1:0]  m_user_reg;

    logic              dense;
    logic              flat_upd;
    logic [30:0]       x_prod;
    logic [30:0]       x_shift;
    logic [X_W-1:0]    x_next;
    logic [49:0]       att_prod;
    logic [24:0]       att_next;
    logic [24:0]       om;
    logic [49:0]       w_prod;
    logic [49:0]       t_prod;
    logic [40:0]       dc_prod [3];
    logic [41:0]       acc_prod [3];
    logic [COLOR_BITS+1:0] acc_sum [3];
    logic [COLOR_BITS-1:0] acc_next [3];

    assign dense    = (dens_reg != 16'd0) && !dens_reg[15];
    assign flat_upd = !deep_reg && dense && !stop_reg;

    assign x_prod   = 31'(ext_reg) * 31'(dens_reg[14:0]);
    assign x_shift  = x_prod >> (16 - EXP_FRAC_BITS);
    assign x_next   = (x_shift > 31'({X_W{1'b1}})) ? {X_W{1'b1}} : x_shift[X_W-1:0];

    assign att_prod = 50'(EI_ROM[x_reg[X_W-1:EXP_FRAC_BITS]]) *
                      50'(EF_ROM[x_reg[EXP_FRAC_BITS-1:0]]);
    assign att_next = dense ? 25'((att_prod + 50'h800000) >> 24) : ONE_Q24;

    assign om     = ONE_Q24 - att_reg;
    assign w_prod = 50'(t_reg) * 50'(om);
    assign t_prod = 50'(t_reg) * 50'(att_reg);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dc_prod[i]  = 41'(col_reg[i]) * 41'(om);
            acc_prod[i] = 42'(col_reg[i]) * 42'(w_reg);
            acc_sum[i]  = (COLOR_BITS + 2)'(acc_reg[i]) +
                          (COLOR_BITS + 2)'((acc_prod[i] + (42'd1 << (39 - COLOR_BITS)))
                                            >> (40 - COLOR_BITS));
            acc_next[i] = (acc_sum[i] > (COLOR_BITS + 2)'({COLOR_BITS{1'b1}})) ?
                          {COLOR_BITS{1'b1}} : acc_sum[i][COLOR_BITS-1:0];
        end
    end

    assign status.need_out = deep_reg ? (dense || last_reg) : last_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg  <= 16'd256;
            deep_reg <= 1'b0;
            thr_reg  <= 24'd2;
        end else if (cfg_we) begin
            priority case (cfg_addr)
                REG_EXTINCTION: ext_reg  <= cfg_wdata[15:0];
                REG_DEEP_MODE:  deep_reg <= cfg_wdata[0];
                REG_THRESHOLD:  thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dens_reg   <= s_tdata[15:0];
            col_reg[0] <= s_tdata[31:16];
            col_reg[1] <= s_tdata[47:32];
            col_reg[2] <= s_tdata[63:48];
            dep_reg    <= s_tdata[87:64];
            last_reg   <= s_tlast;
        end
        if (cmd.calc_x) begin
            x_reg <= x_next;
        end
        if (cmd.calc_att) begin
            att_reg <= att_next;
        end
        if (cmd.calc_w) begin
            w_reg    <= 25'((w_prod + 50'h800000) >> 24);
            tnew_reg <= 25'((t_prod + 50'h800000) >> 24);
            for (int i = 0; i < 3; i++) begin
                dcol_reg[i] <= 16'((dc_prod[i] + 41'h800000) >> 24);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg    <= ONE_Q24;
            stop_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (cmd.calc_acc && flat_upd) begin
            t_reg    <= tnew_reg;
            stop_reg <= (tnew_reg < 25'(thr_reg));
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= acc_next[i];
            end
        end else if (cmd.finish && last_reg) begin
            t_reg    <= ONE_Q24;
            stop_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish && status.need_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && status.need_out) begin
            m_last_reg <= last_reg;
            if (deep_reg && dense) begin
                m_data_reg <= {dep_reg, alpha_of(att_reg), dcol_reg[2], dcol_reg[1],
                               dcol_reg[0]};
                m_user_reg <= 2'b01;
            end else if (deep_reg) begin
                m_data_reg <= '0;
                m_user_reg <= 2'b00;
            end else begin
                m_data_reg <= {24'd0, alpha_of(t_reg), acc_to_q16(acc_reg[2]),
                               acc_to_q16(acc_reg[1]), acc_to_q16(acc_reg[0])};
                m_user_reg <= {stop_reg, 1'b1};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- sv/volume_ray_compositor_top.sv -----
// Top level of the volume ray compositor: joins controller and datapath.
// Depends on vrc_pkg, vrc_ctrl and vrc_datapath.
//
// Usage: one ray sample per s_ transaction. s_tdata carries density, red,
// green, blue emission and sample depth; s_tlast marks the last sample of a ray.
// Results leave on the m_ channel: m_tdata carries red, green, blue, alpha and
// depth, m_tlast marks end of ray, m_tuser carries sample_valid and stopped_early.
// Flat mode gives one pixel per ray on the last sample; deep mode gives one
// result per dense sample and an empty end marker for a skipped last sample.
// A sample steps through capture, x multiply, exp lookup and multiply,
// transmittance multiply, accumulate and emit. The controller holds one
// sample at a time, so the next sample is accepted only once the last one
// has left the emit step.
// A result waits in the output register while m_tready is low; the next sample
// is accepted meanwhile and stalls only at its emit step until the register
// frees. Reset restores extinction 1.0, flat mode, threshold 2 and a clear ray.
// Write configuration through cfg_we / cfg_addr / cfg_wdata while idle only.
module volume_ray_compositor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // density, emit_red, emit_green, emit_blue, sample_depth
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // red, green, blue, alpha, depth
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // sample_valid, stopped_early
);
    import vrc_pkg::*;

    vrc_cmd_t    cmd;
    vrc_status_t status;

    vrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vrc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
